FILE: hw/rtl/per_cpu_page_free_list_allocator_defines.svh
// assertion macros for the page allocator
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PCPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked during reset as well
`define PCPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PCPA_ASSERT(lbl, prop, msg)
`define PCPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/pcpa_pkg.sv
package pcpa_pkg;

  // fixed widths of the words
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CPU_W      = 3;
  localparam int unsigned STATUS_W   = 2;

  // organisation of the managed memory
  localparam int unsigned CPU_COUNT  = 8;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SLOTS = 32768;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned SLOT_W     = $clog2(PAGE_SLOTS);
  localparam int unsigned PG_W       = ADDR_W - PAGE_SHIFT;

  // register map
  localparam int unsigned PADDR_W    = 3;
  localparam logic REG_FIRST_FREE    = 1'b0;
  localparam logic REG_LIMIT         = 1'b1;
  localparam logic [ADDR_W-1:0] FIRST_FREE_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] LIMIT_RESET      = 32'h8800_0000;

  // request kinds
  localparam logic FUNC_FREE  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  // list link: null flag over a slot number
  typedef struct packed {
    logic              null_f;
    logic [SLOT_W-1:0] slot;
  } link_t;

  localparam int unsigned LINK_W = $bits(link_t);

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [ADDR_W-1:0] first_free;
    logic [ADDR_W-1:0] limit;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_e;

endpackage

FILE: hw/rtl/pcpa_link_ram.sv
module pcpa_link_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read port, read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/pcpa_cfg_regs.sv
module pcpa_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output pcpa_pkg::cfg_t                 cfg_o
);

  import pcpa_pkg::*;

  logic           wr_en;
  logic           reg_sel;
  cfg_t           cfg_q;
  cfg_t           cfg_d;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_FREE: cfg_d.first_free = pwdata;
        REG_LIMIT:      cfg_d.limit      = pwdata;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_free <= FIRST_FREE_RESET;
      cfg_q.limit      <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_FIRST_FREE: prdata = cfg_q.first_free;
      REG_LIMIT:      prdata = cfg_q.limit;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/per_cpu_page_free_list_allocator.sv
// a new request is taken only in the idle state, after the last result is loaded;
//   free and refused requests load their result word in the execute state, allocate
//   in the pop state, after the single link ram read (registered) that each pop needs
//   before the head write; the result word is valid in the cycle after it is loaded
// reset: all eight list heads are set empty at once, no clearing pass; the link ram
//   is not initialised and is only read at slots that were freed in
`include "per_cpu_page_free_list_allocator_defines.svh"

module per_cpu_page_free_list_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // cpu[2:0], address[34:3], zero
  input  logic [0:0]                      s_axis_tuser,  // func[0]
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // page_address[31:0]
  output logic [1:0]                      m_axis_tuser,  // status[1:0]
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcpa_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import pcpa_pkg::*;

  cfg_t                cfg;
  state_e              state_q, state_d;

  // request held during execution
  logic                req_func_q;
  logic [CPU_W-1:0]    req_cpu_q;
  logic [ADDR_W-1:0]   req_addr_q;

  link_t               heads_q [CPU_COUNT];
  logic [CPU_W-1:0]    pop_cpu_q, pop_cpu_d;
  logic [SLOT_W-1:0]   pop_slot_q, pop_slot_d;

  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic                in_accept;
  logic                out_free;
  logic                out_load;

  // link ram port
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  link_t               ram_wdata, ram_rdata;

  // head write port
  logic                head_we;
  logic [CPU_W-1:0]    head_idx;
  link_t               head_wdata;

  // address checks and slot arithmetic
  logic [PG_W:0]       base_pg;
  logic [PG_W:0]       diff_pg;
  logic                cpu_ok;
  logic                free_ok;
  logic [ADDR_W-1:0]   pop_addr;
  logic [PG_W-1:0]     pop_pg;

  // list selection for allocate
  logic                found;
  logic [CPU_W-1:0]    sel_cpu;

  pcpa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcpa_link_ram #(
    .DEPTH (PAGE_SLOTS),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // managed base in pages, rounded up, with a carry bit for overflow
  assign base_pg = {1'b0, cfg.first_free[ADDR_W-1:PAGE_SHIFT]}
                 + {{PG_W{1'b0}}, (cfg.first_free[PAGE_SHIFT-1:0] != '0)};

  // free request checks
  assign diff_pg = {1'b0, req_addr_q[ADDR_W-1:PAGE_SHIFT]} - base_pg;
  assign cpu_ok  = 32'(req_cpu_q) < CPU_COUNT;
  assign free_ok = cpu_ok
                && (req_addr_q[PAGE_SHIFT-1:0] == '0)
                && (req_addr_q >= cfg.first_free)
                && (req_addr_q < cfg.limit)
                && !diff_pg[PG_W]
                && (diff_pg[PG_W-1:SLOT_W] == '0);

  // own list first, else the lowest-numbered non-empty list
  always_comb begin
    logic             any;
    logic [CPU_W-1:0] pick;
    any  = 1'b0;
    pick = '0;
    for (int c = CPU_COUNT - 1; c >= 0; c--) begin
      if (!heads_q[c].null_f) begin
        any  = 1'b1;
        pick = CPU_W'(c);
      end
    end
    if (cpu_ok && !heads_q[req_cpu_q].null_f) begin
      found   = 1'b1;
      sel_cpu = req_cpu_q;
    end else begin
      found   = any;
      sel_cpu = pick;
    end
  end

  // slot back to a byte address, wrapping at 32 bits
  assign pop_pg   = base_pg[PG_W-1:0] + PG_W'(pop_slot_q);
  assign pop_addr = {pop_pg, {PAGE_SHIFT{1'b0}}};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_func_q == FUNC_ALLOC && found) begin
          state_d = S_POP;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = diff_pg[SLOT_W-1:0];
    ram_wdata     = heads_q[req_cpu_q];
    ram_re        = 1'b0;
    ram_raddr     = heads_q[sel_cpu].slot;
    head_we       = 1'b0;
    head_idx      = req_cpu_q;
    head_wdata    = '{null_f: 1'b0, slot: diff_pg[SLOT_W-1:0]};
    out_load      = 1'b0;
    out_addr_d    = '0;
    out_status_d  = STATUS_DONE;
    pop_cpu_d     = pop_cpu_q;
    pop_slot_d    = pop_slot_q;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_EXEC: begin
        if (req_func_q == FUNC_ALLOC && found) begin
          // fetch the link below the top page
          ram_re     = 1'b1;
          pop_cpu_d  = sel_cpu;
          pop_slot_d = heads_q[sel_cpu].slot;
        end else if (out_free) begin
          out_load = 1'b1;
          if (req_func_q == FUNC_ALLOC) begin
            out_status_d = STATUS_EMPTY;
          end else if (free_ok) begin
            // push: link the old head under the freed page
            ram_we  = 1'b1;
            head_we = 1'b1;
          end else begin
            out_status_d = STATUS_BAD;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_addr_d = pop_addr;
          head_we    = 1'b1;
          head_idx   = pop_cpu_q;
          head_wdata = ram_rdata;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        heads_q[c] <= '{null_f: 1'b1, slot: '0};
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (head_we) begin
        heads_q[head_idx] <= head_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_func_q <= s_axis_tuser[0];
      req_cpu_q  <= s_axis_tdata[CPU_W-1:0];
      req_addr_q <= s_axis_tdata[CPU_W +: ADDR_W];
    end
    pop_cpu_q  <= pop_cpu_d;
    pop_slot_q <= pop_slot_d;
    if (out_load) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  // checks
  `PCPA_ASSERT(a_accept_to_exec, in_accept |=> (state_q == S_EXEC), "accepted word not executed")
  `PCPA_ASSERT(a_read_to_pop, ram_re |=> (state_q == S_POP), "link read without pop cycle")
  `PCPA_ASSERT(a_fail_no_addr, (m_axis_tvalid && (m_axis_tuser != STATUS_DONE)) |-> (m_axis_tdata == '0), "failed result carries an address")
  `PCPA_ASSERT(a_load_from_work, $rose(out_valid_q) |-> ($past(state_q) != S_IDLE), "result without a request")
  `PCPA_ASSERT_ALWAYS(a_single_port_use, !(ram_we && ram_re), "link ram read and written together")

endmodule

FILE: sim/tb_per_cpu_page_free_list_allocator.sv
module tb_per_cpu_page_free_list_allocator;
  import pcpa_pkg::*;

  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 215;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned PROBES          = 25;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
  } page_result_t;

  // one directed request, with the answer typed in where it is obvious
  typedef struct packed {
    logic              func;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] address;
    logic              typed;
    page_result_t      want;
  } probe_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // cpu[2:0], address[34:3], zero
  logic [0:0]  s_axis_tuser;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // page_address[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  per_cpu_page_free_list_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the allocator: registers, list heads and link words
  logic [ADDR_W-1:0] cfg_first_free;
  logic [ADDR_W-1:0] cfg_limit;
  link_t             head_of [CPU_COUNT];
  link_t             link_of [PAGE_SLOTS];
  bit                page_listed [PAGE_SLOTS];

  page_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  send_calm = 0;
  bit           long_hold_req = 0;

  // directed requests under the reset register values
  probe_t probe_tab [PROBES] = '{
    '{FUNC_ALLOC, 3'd0, 32'hFFFF_FFFF, 1'b1, '{32'h0, STATUS_EMPTY}},
    '{FUNC_FREE,  3'd0, 32'h8000_0000, 1'b1, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd7, 32'h87FF_F000, 1'b1, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd1, 32'h8000_0800, 1'b1, '{32'h0, STATUS_BAD}},
    '{FUNC_FREE,  3'd1, 32'h7FFF_F000, 1'b1, '{32'h0, STATUS_BAD}},
    '{FUNC_FREE,  3'd1, 32'h8800_0000, 1'b1, '{32'h0, STATUS_BAD}},
    '{FUNC_FREE,  3'd1, 32'hFFFF_F000, 1'b1, '{32'h0, STATUS_BAD}},
    '{FUNC_FREE,  3'd1, 32'h0000_0000, 1'b1, '{32'h0, STATUS_BAD}},
    '{FUNC_FREE,  3'd0, 32'h8000_1000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd0, 32'h5A5A_5A5A, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd3, 32'hA5A5_A5A5, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd7, 32'h0000_0000, 1'b1, '{32'h0, STATUS_EMPTY}},
    '{FUNC_FREE,  3'd6, 32'h8000_2000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd4, 32'h8000_3000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd7, 32'h1234_5678, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd2, 32'hFFFF_FFFF, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd2, 32'h8000_5000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd2, 32'h8000_5000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd2, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd2, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_FREE,  3'd5, 32'h8000_5000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd2, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd5, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{FUNC_ALLOC, 3'd5, 32'h0000_0000, 1'b1, '{32'h0, STATUS_EMPTY}}
  };

  // register settings for the random phases, extremes included
  logic [ADDR_W-1:0] phase_first [PHASES] = '{
    32'h8000_0000, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_F000, 32'hFFFF_F001,
    32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0800, 32'h8000_0000
  };
  logic [ADDR_W-1:0] phase_limit [PHASES] = '{
    32'h8800_0000, 32'hFFFF_FFFF, 32'h1240_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h4010_0000, 32'h8004_0000
  };

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  // first_free rounded up to a page, one bit wider to hold the overflow
  function automatic logic [ADDR_W:0] managed_base();
    logic [ADDR_W:0] sum;
    sum = {1'b0, cfg_first_free} + (ADDR_W+1)'(PAGE_BYTES - 1);
    return {sum[ADDR_W:PAGE_SHIFT], PAGE_SHIFT'(0)};
  endfunction

  // pop the top page of one list
  function automatic bit take_top(input int unsigned cpu_no, output logic [SLOT_W-1:0] slot);
    slot = '0;
    if (head_of[cpu_no].null_f)
      return 1'b0;
    slot = head_of[cpu_no].slot;
    head_of[cpu_no] = link_of[slot];
    page_listed[slot] = 1'b0;
    return 1'b1;
  endfunction

  // result word of one request, updating the shadow lists
  function automatic page_result_t page_pool_step(input logic f, input logic [CPU_W-1:0] c,
                                                  input logic [ADDR_W-1:0] a);
    page_result_t      res;
    logic [ADDR_W:0]   base;
    logic [ADDR_W:0]   offs;
    logic [SLOT_W-1:0] slot;
    bit                got;
    int unsigned       k;
    res  = '{page_address: '0, status: STATUS_DONE};
    base = managed_base();
    if (f == FUNC_FREE) begin
      offs = {1'b0, a} - base;
      if (c >= CPU_COUNT || a[PAGE_SHIFT-1:0] != '0 || a < cfg_first_free ||
          a >= cfg_limit || {1'b0, a} < base || (offs >> PAGE_SHIFT) >= PAGE_SLOTS) begin
        res.status = STATUS_BAD;
      end else begin
        slot = offs[PAGE_SHIFT +: SLOT_W];
        link_of[slot] = head_of[c];
        head_of[c] = '{null_f: 1'b0, slot: slot};
        page_listed[slot] = 1'b1;
      end
    end else begin
      got = 1'b0;
      if (c < CPU_COUNT)
        got = take_top(c, slot);
      // steal from the lowest-numbered other list
      for (k = 0; !got && k < CPU_COUNT; k++)
        if (k != c)
          got = take_top(k, slot);
      if (!got)
        res.status = STATUS_EMPTY;
      else
        res.page_address = ADDR_W'(base + ((ADDR_W+1)'(slot) << PAGE_SHIFT));
    end
    return res;
  endfunction

  // idle cycles between request words: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_calm = $urandom_range(30, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic f, input logic [CPU_W-1:0] c,
                           input logic [ADDR_W-1:0] a, input logic typed,
                           input page_result_t typed_res);
    page_result_t pred;
    int unsigned  gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, a, c};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = page_pool_step(f, c, a);
    pending_results.push_back(typed ? typed_res : pred);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // write a register, then read it back
  task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_FIRST_FREE)
      cfg_first_free = value;
    else
      cfg_limit = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      note_mismatch("register read-back", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly well-formed frees of unlisted pages and allocates, some edge and noise words
  task automatic random_request(output logic f, output logic [CPU_W-1:0] c,
                                output logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] base;
    logic [ADDR_W:0] span;
    int unsigned     n_win;
    int unsigned     reach;
    int unsigned     s;
    int unsigned     r;
    int unsigned     tries;
    base  = managed_base();
    n_win = 0;
    if ({1'b0, cfg_limit} > base) begin
      span  = ({1'b0, cfg_limit} - base + (ADDR_W+1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
      n_win = (span > PAGE_SLOTS) ? PAGE_SLOTS : int'(span);
    end
    c = CPU_W'($urandom_range(0, CPU_COUNT - 1));
    a = $urandom;
    f = FUNC_ALLOC;
    r = $urandom_range(0, 99);
    if (r >= 48 && r < 82 && n_win > 0) begin
      reach = (n_win < 64) ? n_win : 64;
      tries = 0;
      do begin
        s = ($urandom_range(0, 15) == 0) ? $urandom_range(0, n_win - 1)
                                         : $urandom_range(0, reach - 1);
        tries++;
      end while (page_listed[s] && tries < 8);
      if (!page_listed[s]) begin
        f = FUNC_FREE;
        a = ADDR_W'(base + ((ADDR_W+1)'(s) << PAGE_SHIFT));
      end
    end else if (r >= 82 && r < 90) begin
      f = FUNC_FREE;
      case ($urandom_range(0, 3))
        0: a = cfg_limit;
        1: a = ADDR_W'(base + ((ADDR_W+1)'(n_win) << PAGE_SHIFT));
        2: a = ADDR_W'(base - PAGE_BYTES);
        default: a = cfg_first_free - 1;
      endcase
    end else if (r >= 90) begin
      f = FUNC_FREE;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result sink: random back-pressure, one long hold-off on request
  initial begin : result_sink
    int unsigned run_left;
    int unsigned r;
    logic        ready_level;
    run_left      = 0;
    ready_level   = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        ready_level   = 1'b0;
        run_left      = LONG_HOLD;
      end else if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          ready_level = 1'b1;
          run_left    = $urandom_range(50, 150);
        end else if (r < 60) begin
          ready_level = 1'b1;
          run_left    = $urandom_range(1, 8);
        end else if (r < 90) begin
          ready_level = 1'b0;
          run_left    = $urandom_range(1, 3);
        end else if (r < 97) begin
          ready_level = 1'b0;
          run_left    = $urandom_range(4, 12);
        end else begin
          ready_level = 1'b0;
          run_left    = $urandom_range(20, 60);
        end
      end
      m_axis_tready <= rst_ni ? ready_level : 1'b0;
      run_left--;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result word", '0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.page_address)
          note_mismatch("page address", want.page_address, m_axis_tdata);
        if (m_axis_tuser !== want.status)
          note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
      end
    end
  end

  initial begin : stimulus
    int unsigned       k;
    int unsigned       p;
    logic              f;
    logic [CPU_W-1:0]  c;
    logic [ADDR_W-1:0] a;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cfg_first_free = FIRST_FREE_RESET;
    cfg_limit      = LIMIT_RESET;
    for (k = 0; k < CPU_COUNT; k++)
      head_of[k] = '{null_f: 1'b1, slot: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset values
    for (k = 0; k < PROBES; k++)
      send_word(probe_tab[k].func, probe_tab[k].cpu, probe_tab[k].address,
                probe_tab[k].typed, probe_tab[k].want);
    wait_drained();

    // random phases, lists carried over each register change
    for (p = 0; p < PHASES; p++) begin
      cfg_write(REG_FIRST_FREE, phase_first[p]);
      cfg_write(REG_LIMIT, phase_limit[p]);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 0 && k == 60)
          long_hold_req = 1;
        random_request(f, c, a);
        send_word(f, c, a, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
